// ----- rtl/ecsc_pkg.sv -----
// Types, codes and field tables shared by the encoder clock-set controller.
package ecsc_pkg;

  localparam int unsigned NUM_FIELDS = 5;
  localparam int unsigned ELAPSED_W  = 9;
  localparam int unsigned VALUE_W    = 7;
  localparam int unsigned FOCUS_W    = 3;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
  localparam logic [ELAPSED_W-1:0] ROTARY_QUIET_RESET = 9'd100;
  localparam logic [ELAPSED_W-1:0] KEY_QUIET_RESET    = 9'd300;

  localparam logic [FOCUS_W-1:0] FOCUS_YEAR   = 3'd0;
  localparam logic [FOCUS_W-1:0] FOCUS_MONTH  = 3'd1;
  localparam logic [FOCUS_W-1:0] FOCUS_DAY    = 3'd2;
  localparam logic [FOCUS_W-1:0] FOCUS_HOUR   = 3'd3;
  localparam logic [FOCUS_W-1:0] FOCUS_MINUTE = 3'd4;

  localparam logic [7:0] ADDR_PROTECT   = 8'h8E;
  localparam logic [7:0] ADDR_CLEAR_SEC = 8'h80;

  // Input opcodes.
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_EDGE  = 2'd1;
  localparam logic [1:0] OP_KEY   = 2'd2;
  localparam logic [1:0] OP_SNAP  = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ROTARY_QUIET = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_QUIET    = 1'd1;

  typedef struct packed {
    logic [1:0]         opcode;
    logic               phase_a_level;
    logic               phase_b_level;
    logic [VALUE_W-1:0] snap_year;
    logic [VALUE_W-1:0] snap_month;
    logic [VALUE_W-1:0] snap_day;
    logic [VALUE_W-1:0] snap_hour;
    logic [VALUE_W-1:0] snap_minute;
  } in_item_t;

  typedef struct packed {
    logic               cmd_valid;
    logic [7:0]         cmd_address;
    logic [7:0]         cmd_data;
    logic               refresh;
    logic               edit_mode;
    logic [FOCUS_W-1:0] focus;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic                                mode;
    logic [FOCUS_W-1:0]                  focus;
    logic [ELAPSED_W-1:0]                rotary_elapsed;
    logic [ELAPSED_W-1:0]                key_elapsed;
    logic [NUM_FIELDS-1:0][VALUE_W-1:0]  time_copy;
  } state_t;

  localparam state_t STATE_RESET = '{
    mode:           1'b0,
    focus:          FOCUS_YEAR,
    rotary_elapsed: ELAPSED_MAX,
    key_elapsed:    ELAPSED_MAX,
    time_copy:      '0
  };

  typedef enum logic [1:0] {
    RES_PLAIN,
    RES_EDIT,
    RES_EDIT_MINUTE
  } res_kind_t;

  // Everything needed to replay the result transfers of one item.
  typedef struct packed {
    res_kind_t          kind;
    logic               refresh;
    logic               edit_mode;
    logic [FOCUS_W-1:0] focus;
    logic [7:0]         field_address;
    logic [7:0]         field_data;
  } res_t;

  function automatic logic [7:0] field_address(input logic [FOCUS_W-1:0] f);
    logic [7:0] a;
    case (f)
      FOCUS_YEAR:  a = 8'h8C;
      FOCUS_MONTH: a = 8'h88;
      FOCUS_DAY:   a = 8'h86;
      FOCUS_HOUR:  a = 8'h84;
      default:     a = 8'h82;
    endcase
    return a;
  endfunction

  function automatic logic [VALUE_W-1:0] field_lowest(input logic [FOCUS_W-1:0] f);
    logic [VALUE_W-1:0] m;
    case (f)
      FOCUS_MONTH, FOCUS_DAY: m = 7'd1;
      default:                m = 7'd0;
    endcase
    return m;
  endfunction

  function automatic logic [VALUE_W-1:0] field_highest(input logic [FOCUS_W-1:0] f);
    logic [VALUE_W-1:0] m;
    case (f)
      FOCUS_YEAR:  m = 7'd99;
      FOCUS_MONTH: m = 7'd12;
      FOCUS_DAY:   m = 7'd31;
      FOCUS_HOUR:  m = 7'd23;
      default:     m = 7'd59;
    endcase
    return m;
  endfunction

  // Tens digit by multiplying with 205/2048, exact for all 7-bit values.
  function automatic logic [7:0] to_bcd(input logic [VALUE_W-1:0] v);
    logic [14:0]        prod;
    logic [3:0]         tens;
    logic [VALUE_W-1:0] ones;
    prod = 15'(v) * 15'd205;
    tens = prod[14:11];
    ones = v - 7'(tens) * 7'd10;
    return {tens, ones[3:0]};
  endfunction

endpackage

// ----- rtl/ecsc_step.sv -----
// Next-state and result summary for one input item of the clock-set controller.
module ecsc_step (
  input  ecsc_pkg::in_item_t                 item,
  input  ecsc_pkg::state_t                   st,
  input  logic [ecsc_pkg::ELAPSED_W-1:0]     rotary_quiet,
  input  logic [ecsc_pkg::ELAPSED_W-1:0]     key_quiet,
  output ecsc_pkg::state_t                   st_next,
  output ecsc_pkg::res_t                     res
);

  logic                              rotary_open;
  logic                              key_open;
  logic [ecsc_pkg::FOCUS_W-1:0]      f;
  logic [ecsc_pkg::VALUE_W-1:0]      cur;
  logic [ecsc_pkg::VALUE_W-1:0]      lo;
  logic [ecsc_pkg::VALUE_W-1:0]      hi;
  logic [ecsc_pkg::VALUE_W-1:0]      nv;

  assign rotary_open = st.rotary_elapsed >= rotary_quiet;
  assign key_open    = st.key_elapsed >= key_quiet;

  assign f   = (st.focus > ecsc_pkg::FOCUS_MINUTE) ? ecsc_pkg::FOCUS_MINUTE : st.focus;
  assign cur = st.time_copy[f];
  assign lo  = ecsc_pkg::field_lowest(f);
  assign hi  = ecsc_pkg::field_highest(f);

  always_comb begin
    if (item.phase_b_level) begin
      nv = (cur >= hi) ? lo : cur + 7'd1;
    end else begin
      nv = (cur <= lo || cur > hi) ? hi : cur - 7'd1;
    end
  end

  always_comb begin
    st_next  = st;
    res.kind = ecsc_pkg::RES_PLAIN;
    res.refresh = 1'b0;
    res.field_address = ecsc_pkg::field_address(f);
    res.field_data    = ecsc_pkg::to_bcd(nv);
    case (item.opcode)
      ecsc_pkg::OP_TICK: begin
        if (st.rotary_elapsed != ecsc_pkg::ELAPSED_MAX) begin
          st_next.rotary_elapsed = st.rotary_elapsed + 9'd1;
        end
        if (st.key_elapsed != ecsc_pkg::ELAPSED_MAX) begin
          st_next.key_elapsed = st.key_elapsed + 9'd1;
        end
      end
      ecsc_pkg::OP_KEY: begin
        if (key_open) begin
          st_next.key_elapsed = '0;
          st_next.mode = ~st.mode;
          res.refresh = 1'b1;
        end
      end
      ecsc_pkg::OP_SNAP: begin
        st_next.time_copy[ecsc_pkg::FOCUS_YEAR]   = item.snap_year;
        st_next.time_copy[ecsc_pkg::FOCUS_MONTH]  = item.snap_month;
        st_next.time_copy[ecsc_pkg::FOCUS_DAY]    = item.snap_day;
        st_next.time_copy[ecsc_pkg::FOCUS_HOUR]   = item.snap_hour;
        st_next.time_copy[ecsc_pkg::FOCUS_MINUTE] = item.snap_minute;
        res.refresh = 1'b1;
      end
      ecsc_pkg::OP_EDGE: begin
        // An open lockout is consumed even when phase A is high.
        if (rotary_open) begin
          st_next.rotary_elapsed = '0;
          if (!item.phase_a_level) begin
            res.refresh = 1'b1;
            if (!st.mode) begin
              if (item.phase_b_level) begin
                st_next.focus = (st.focus >= ecsc_pkg::FOCUS_MINUTE) ?
                                ecsc_pkg::FOCUS_YEAR : st.focus + 3'd1;
              end else begin
                st_next.focus = (st.focus == ecsc_pkg::FOCUS_YEAR ||
                                 st.focus > ecsc_pkg::FOCUS_MINUTE) ?
                                ecsc_pkg::FOCUS_MINUTE : st.focus - 3'd1;
              end
            end else begin
              st_next.time_copy[f] = nv;
              res.kind = (f == ecsc_pkg::FOCUS_MINUTE) ?
                         ecsc_pkg::RES_EDIT_MINUTE : ecsc_pkg::RES_EDIT;
            end
          end
        end
      end
      default: begin
      end
    endcase
    res.edit_mode = st_next.mode;
    res.focus     = st_next.focus;
  end

endmodule

// ----- rtl/encoder_clock_set_controller.sv -----
// Top level of the encoder clock-set controller: state, config and result register.
// The first result of an item is offered in the cycle after its transfer.
// One result per cycle while out_ready is high; ticks, key presses, snapshots and non-edit
// edges give one result each, an edit edge two (three for the minute), set by the single result
// register that emits one write command per cycle. A new item is taken on the last one.
// Reset (synchronous, rst high): navigate mode, focus on year, lockout counters at 511,
// time copy zero, quiet times 100 and 300, no result pending.
module encoder_clock_set_controller (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  ecsc_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output ecsc_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ecsc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ecsc_pkg::ELAPSED_W-1:0]    cfg_data
);

  ecsc_pkg::state_t                  st;
  ecsc_pkg::state_t                  st_next;
  ecsc_pkg::res_t                    res;
  ecsc_pkg::res_t                    res_next;
  logic [ecsc_pkg::ELAPSED_W-1:0]    rotary_quiet;
  logic [ecsc_pkg::ELAPSED_W-1:0]    key_quiet;
  logic [1:0]                        res_idx;
  logic [1:0]                        res_final;
  logic                              is_final;
  logic                              in_xfer;
  logic                              out_xfer;

  ecsc_step u_step (
    .item         (in_data),
    .st           (st),
    .rotary_quiet (rotary_quiet),
    .key_quiet    (key_quiet),
    .st_next      (st_next),
    .res          (res_next)
  );

  always_comb begin
    case (res.kind)
      ecsc_pkg::RES_EDIT:        res_final = 2'd1;
      ecsc_pkg::RES_EDIT_MINUTE: res_final = 2'd2;
      default:                   res_final = 2'd0;
    endcase
  end

  assign is_final  = res_idx == res_final;
  assign in_ready  = !out_valid || (out_ready && is_final);
  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid && out_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotary_quiet <= ecsc_pkg::ROTARY_QUIET_RESET;
      key_quiet    <= ecsc_pkg::KEY_QUIET_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        ecsc_pkg::CFG_ROTARY_QUIET: rotary_quiet <= cfg_data;
        ecsc_pkg::CFG_KEY_QUIET:    key_quiet    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ecsc_pkg::STATE_RESET;
      out_valid <= 1'b0;
      res_idx   <= '0;
    end else begin
      if (in_xfer) begin
        st        <= st_next;
        out_valid <= 1'b1;
        res_idx   <= '0;
      end else if (out_xfer) begin
        if (is_final) begin
          out_valid <= 1'b0;
        end else begin
          res_idx <= res_idx + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res <= res_next;
    end
  end

  // Edit sequence: write-protect clear, field write, then seconds clear for the minute.
  always_comb begin
    out_data.cmd_valid   = 1'b0;
    out_data.cmd_address = 8'h00;
    out_data.cmd_data    = 8'h00;
    if (res.kind != ecsc_pkg::RES_PLAIN) begin
      out_data.cmd_valid = 1'b1;
      case (res_idx)
        2'd0: out_data.cmd_address = ecsc_pkg::ADDR_PROTECT;
        2'd1: begin
          out_data.cmd_address = res.field_address;
          out_data.cmd_data    = res.field_data;
        end
        default: out_data.cmd_address = ecsc_pkg::ADDR_CLEAR_SEC;
      endcase
    end
    out_data.refresh   = res.refresh;
    out_data.edit_mode = res.edit_mode;
    out_data.focus     = res.focus;
    out_data.last      = is_final;
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> res_idx <= res_final)
    else $error("result index beyond the item's last result");

  a_in_gives_out: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> out_valid && res_idx == 2'd0)
    else $error("accepted item did not start a result sequence");

  a_cmd_only_in_edit: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.cmd_valid |-> out_data.edit_mode && out_data.refresh)
    else $error("write command outside edit mode");

  a_focus_range: assert property (@(posedge clk) disable iff (rst)
    st.focus <= ecsc_pkg::FOCUS_MINUTE)
    else $error("focus beyond the minute field");

  a_mode_toggle_key: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) && st.mode != $past(st.mode) |-> $past(in_xfer) &&
    $past(in_data.opcode) == ecsc_pkg::OP_KEY)
    else $error("mode changed without a key press");

endmodule
